/* src/ipv6_canonical_formatter_core_defines.svh */
// Assertion macros shared by the formatter modules.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef IPV6_CANONICAL_FORMATTER_CORE_DEFINES_SVH
`define IPV6_CANONICAL_FORMATTER_CORE_DEFINES_SVH

// Check that cons holds in the same cycle as ante
`define IPV6CF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante
`define IPV6CF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/ipv6cf_pkg.sv */
package ipv6cf_pkg;

  localparam int NUM_GROUPS     = 8;
  localparam int GROUP_W        = 16;
  localparam int CHAR_W         = 7;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [CHAR_W-1:0] CH_COLON = 7'h3a;
  localparam logic [CHAR_W-1:0] CH_DOT   = 7'h2e;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_HEX_A = 7'h57;  // 'a' minus ten

  // One classified request waiting for the text sequencer
  typedef struct packed {
    logic [NUM_GROUPS-1:0][GROUP_W-1:0] grp;
    logic                               has_run;
    logic [2:0]                         run_first;
    logic [3:0]                         run_end;   // first group after the run
    logic                               mapped;
  } job_t;

  typedef enum logic [2:0] {
    B_START,
    B_RUN,
    B_SEP,
    B_DIG,
    B_DEC,
    B_DOT,
    B_TAIL
  } back_state_t;

  // Position of the highest nonzero nibble, zero for a zero group
  function automatic logic [1:0] lead_nib(input logic [GROUP_W-1:0] v);
    if (v[15:12] != 4'h0) begin
      return 2'd3;
    end else if (v[11:8] != 4'h0) begin
      return 2'd2;
    end else if (v[7:4] != 4'h0) begin
      return 2'd1;
    end else begin
      return 2'd0;
    end
  endfunction

  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return CH_ZERO + {3'b000, nib};
    end else begin
      return CH_HEX_A + {3'b000, nib};
    end
  endfunction

  // Split an octet into hundreds, tens and ones: {h[1:0], t[3:0], o[3:0]}
  function automatic logic [9:0] dec_split(input logic [7:0] v);
    logic [1:0] h;
    logic [7:0] r;
    logic [3:0] t;
    logic [7:0] o;
    int         k;
    if (v >= 8'd200) begin
      h = 2'd2;
      r = v - 8'd200;
    end else if (v >= 8'd100) begin
      h = 2'd1;
      r = v - 8'd100;
    end else begin
      h = 2'd0;
      r = v;
    end
    t = 4'd0;
    for (k = 1; k < 10; k++) begin
      if (r >= 8'(k * 10)) begin
        t = 4'(k);
      end
    end
    o = r - ({4'b0000, t} << 3) - ({4'b0000, t} << 1);
    return {h, t, o[3:0]};
  endfunction

  // Position of the leading decimal digit of a split octet
  function automatic logic [1:0] lead_dec(input logic [9:0] d);
    if (d[9:8] != 2'd0) begin
      return 2'd2;
    end else if (d[7:4] != 4'd0) begin
      return 2'd1;
    end else begin
      return 2'd0;
    end
  endfunction

endpackage

/* src/ipv6cf_front.sv */
module ipv6cf_front (
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ipv6cf_pkg::GROUP_W-1:0]  in_group_0,
  input  logic [ipv6cf_pkg::GROUP_W-1:0]  in_group_1,
  input  logic [ipv6cf_pkg::GROUP_W-1:0]  in_group_2,
  input  logic [ipv6cf_pkg::GROUP_W-1:0]  in_group_3,
  input  logic [ipv6cf_pkg::GROUP_W-1:0]  in_group_4,
  input  logic [ipv6cf_pkg::GROUP_W-1:0]  in_group_5,
  input  logic [ipv6cf_pkg::GROUP_W-1:0]  in_group_6,
  input  logic [ipv6cf_pkg::GROUP_W-1:0]  in_group_7,
  input  logic                            q_full,
  output logic                            q_push,
  output ipv6cf_pkg::job_t                q_job
);
  import ipv6cf_pkg::*;

  logic [NUM_GROUPS-1:0][GROUP_W-1:0] grp;
  logic [2:0] long_pos;
  logic [3:0] long_cnt;
  logic [2:0] cur_start;
  logic [3:0] cur_len;
  logic       in_zero_run;
  logic       has_run;

  // Stall while the queue has no free slot
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  assign grp = {in_group_7, in_group_6, in_group_5, in_group_4,
                in_group_3, in_group_2, in_group_1, in_group_0};

  // Find the first longest run of zero groups
  always_comb begin
    long_pos    = 3'd0;
    long_cnt    = 4'd0;
    cur_start   = 3'd0;
    cur_len     = 4'd0;
    in_zero_run = 1'b0;
    for (int i = 0; i < NUM_GROUPS; i++) begin
      if (grp[i] != '0) begin
        in_zero_run = 1'b0;
      end else begin
        if (!in_zero_run) begin
          cur_start   = 3'(i);
          cur_len     = 4'd0;
          in_zero_run = 1'b1;
        end
        cur_len = cur_len + 4'd1;
        if (cur_len > long_cnt) begin
          long_cnt = cur_len;
          long_pos = cur_start;
        end
      end
    end
  end

  // Pack the classified request
  assign has_run = (long_cnt >= 4'd2);

  always_comb begin
    q_job.grp       = grp;
    q_job.has_run   = has_run;
    q_job.run_first = long_pos;
    q_job.run_end   = {1'b0, long_pos} + long_cnt;
    q_job.mapped    = has_run && (long_pos == 3'd0) && (long_cnt == 4'd5)
                      && (in_group_5 == 16'hffff);
  end

endmodule

/* src/ipv6cf_queue.sv */
`include "ipv6_canonical_formatter_core_defines.svh"

module ipv6cf_queue #(
  parameter int DEPTH = ipv6cf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ipv6cf_pkg::job_t push_job,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output ipv6cf_pkg::job_t head_job
);
  import ipv6cf_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  job_t            slot_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == FullCnt);
  assign head_valid = (cnt_r != '0);
  assign head_job   = slot_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store incoming requests
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  `IPV6CF_ASSERT_IMPL(a_no_push_full, push, cnt_r < FullCnt, "queue overflow")
  `IPV6CF_ASSERT_IMPL(a_no_pop_empty, pop, cnt_r != '0, "queue underflow")
  `IPV6CF_ASSERT_NEXT(a_push_fills, push && !pop, cnt_r != '0, "push lost")

endmodule

/* src/ipv6cf_back.sv */
`include "ipv6_canonical_formatter_core_defines.svh"

module ipv6cf_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           job_valid,
  input  ipv6cf_pkg::job_t               job,
  output logic                           job_pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ipv6cf_pkg::CHAR_W-1:0]  out_char_code,
  output logic                           out_last
);
  import ipv6cf_pkg::*;

  back_state_t       st_r, st_nxt;
  logic [2:0]        gi_r, gi_nxt;
  logic [1:0]        np_r, np_nxt;
  logic [1:0]        oi_r, oi_nxt;
  logic [1:0]        dp_r, dp_nxt;
  logic              out_valid_r;
  logic [CHAR_W-1:0] out_char_r;
  logic              out_last_r;

  logic              fire;
  logic [CHAR_W-1:0] cur_char;
  logic              cur_last;
  logic [3:0]        ent_gi;
  logic [2:0]        ent_idx;
  logic              ent_in_run;
  back_state_t       ent_state;
  logic [7:0]        octet;
  logic [9:0]        dsplit;
  logic [7:0]        next_octet;
  logic [9:0]        next_dsplit;
  logic [3:0]        dec_digit;

  // Emit one character whenever the output register is free
  assign fire = (st_r != B_START) && (!out_valid_r || !out_stall);

  // Pick the octet of groups six and seven for the dotted form
  always_comb begin
    case (oi_r)
      2'd0:    octet = job.grp[6][15:8];
      2'd1:    octet = job.grp[6][7:0];
      2'd2:    octet = job.grp[7][15:8];
      default: octet = job.grp[7][7:0];
    endcase
    case (oi_r + 2'd1)
      2'd0:    next_octet = job.grp[6][15:8];
      2'd1:    next_octet = job.grp[6][7:0];
      2'd2:    next_octet = job.grp[7][15:8];
      default: next_octet = job.grp[7][7:0];
    endcase
  end

  assign dsplit      = dec_split(octet);
  assign next_dsplit = dec_split(next_octet);

  always_comb begin
    case (dp_r)
      2'd2:    dec_digit = {2'b00, dsplit[9:8]};
      2'd1:    dec_digit = dsplit[7:4];
      default: dec_digit = dsplit[3:0];
    endcase
  end

  // Select the group to enter next
  always_comb begin
    case (st_r)
      B_RUN:   ent_gi = job.run_end;
      B_DIG:   ent_gi = {1'b0, gi_r} + 4'd1;
      default: ent_gi = 4'd0;
    endcase
  end

  assign ent_idx    = ent_gi[2:0];
  assign ent_in_run = job.has_run && (ent_idx >= job.run_first)
                      && ({1'b0, ent_idx} < job.run_end);

  // Decide how the entered group starts
  always_comb begin
    if (ent_gi[3]) begin
      ent_state = B_TAIL;
    end else if (ent_in_run) begin
      ent_state = B_RUN;
    end else if (ent_idx != 3'd0) begin
      ent_state = B_SEP;
    end else begin
      ent_state = B_DIG;
    end
  end

  // Sequence characters of the current request
  always_comb begin
    st_nxt   = st_r;
    gi_nxt   = gi_r;
    np_nxt   = np_r;
    oi_nxt   = oi_r;
    dp_nxt   = dp_r;
    cur_char = CH_COLON;
    cur_last = 1'b0;
    case (st_r)
      B_START: begin
        if (job_valid) begin
          st_nxt = ent_state;
          gi_nxt = ent_idx;
          np_nxt = lead_nib(job.grp[ent_idx]);
          oi_nxt = 2'd0;
        end
      end
      B_RUN: begin
        cur_char = CH_COLON;
        if (fire) begin
          st_nxt = ent_state;
          gi_nxt = ent_idx;
          np_nxt = lead_nib(job.grp[ent_idx]);
        end
      end
      B_SEP: begin
        cur_char = CH_COLON;
        if (fire) begin
          if (job.mapped && (gi_r == 3'd6)) begin
            st_nxt = B_DEC;
            oi_nxt = 2'd0;
            dp_nxt = lead_dec(dsplit);
          end else begin
            st_nxt = B_DIG;
            np_nxt = lead_nib(job.grp[gi_r]);
          end
        end
      end
      B_DIG: begin
        cur_char = hex_char(job.grp[gi_r][{np_r, 2'b00} +: 4]);
        cur_last = (np_r == 2'd0) && (gi_r == 3'd7);
        if (fire) begin
          if (np_r != 2'd0) begin
            np_nxt = np_r - 2'd1;
          end else if (gi_r == 3'd7) begin
            st_nxt = B_START;
          end else begin
            st_nxt = ent_state;
            gi_nxt = ent_idx;
            np_nxt = lead_nib(job.grp[ent_idx]);
          end
        end
      end
      B_DEC: begin
        cur_char = CH_ZERO + {3'b000, dec_digit};
        cur_last = (dp_r == 2'd0) && (oi_r == 2'd3);
        if (fire) begin
          if (dp_r != 2'd0) begin
            dp_nxt = dp_r - 2'd1;
          end else if (oi_r == 2'd3) begin
            st_nxt = B_START;
          end else begin
            st_nxt = B_DOT;
          end
        end
      end
      B_DOT: begin
        cur_char = CH_DOT;
        if (fire) begin
          st_nxt = B_DEC;
          oi_nxt = oi_r + 2'd1;
          dp_nxt = lead_dec(next_dsplit);
        end
      end
      B_TAIL: begin
        cur_char = CH_COLON;
        cur_last = 1'b1;
        if (fire) begin
          st_nxt = B_START;
        end
      end
      default: begin
        st_nxt = B_START;
      end
    endcase
  end

  // Drop the request once its final character is emitted
  assign job_pop = fire && cur_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_START;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold counters and output payload
  always_ff @(posedge clk) begin
    gi_r <= gi_nxt;
    np_r <= np_nxt;
    oi_r <= oi_nxt;
    dp_r <= dp_nxt;
    if (fire) begin
      out_char_r <= cur_char;
      out_last_r <= cur_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last      = out_last_r;

  `IPV6CF_ASSERT_IMPL(a_busy_has_job, st_r != B_START, job_valid, "sequencer without request")
  `IPV6CF_ASSERT_IMPL(a_tail_run_end, st_r == B_TAIL, job.has_run && job.run_end == 4'd8,
                      "trailing colon without run at end")
  `IPV6CF_ASSERT_IMPL(a_dec_mapped, st_r == B_DEC, job.mapped && gi_r == 3'd6,
                      "dotted form outside mapped address")
  `IPV6CF_ASSERT_IMPL(a_run_start, st_r == B_RUN, job.has_run && gi_r == job.run_first,
                      "elision outside run start")

endmodule

/* src/ipv6_canonical_formatter_core.sv */
// Canonical IPv6 text formatter.
// Input channel: one request per address, eight 16-bit groups (in_group_0
// most significant), accepted when in_valid is high and in_stall is low.
// Output channel: one ASCII character per transfer on out_char_code, with
// out_last set on the final character; taken when out_valid is high and
// out_stall is low. Text is 2 to 39 characters long.
// A classifier finds the zero run to elide and the mapped form, and places
// the request in a small queue; a sequencer then walks the groups and emits
// one character per cycle, while the receiver does not stall, into an
// output register. An accepted request is written into the queue; the
// sequencer loads it from the queue head in a separate step and then
// registers each character in the output register, so it takes the next
// request only after the last character of the previous one.
// in_stall rises only when the queue is full; the classifier takes further
// requests while the sequencer is busy or the receiver stalls.
// A stalled output holds its character; the sequencer waits for it.
// Synchronous reset empties the queue and drops any partly emitted text.
module ipv6_canonical_formatter_core #(
  parameter int QUEUE_DEPTH = ipv6cf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [ipv6cf_pkg::GROUP_W-1:0] in_group_0,
  input  logic [ipv6cf_pkg::GROUP_W-1:0] in_group_1,
  input  logic [ipv6cf_pkg::GROUP_W-1:0] in_group_2,
  input  logic [ipv6cf_pkg::GROUP_W-1:0] in_group_3,
  input  logic [ipv6cf_pkg::GROUP_W-1:0] in_group_4,
  input  logic [ipv6cf_pkg::GROUP_W-1:0] in_group_5,
  input  logic [ipv6cf_pkg::GROUP_W-1:0] in_group_6,
  input  logic [ipv6cf_pkg::GROUP_W-1:0] in_group_7,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ipv6cf_pkg::CHAR_W-1:0]  out_char_code,
  output logic                           out_last
);
  import ipv6cf_pkg::*;

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_valid;
  job_t push_job;
  job_t head_job;

  // Classify incoming requests
  ipv6cf_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_group_0 (in_group_0),
    .in_group_1 (in_group_1),
    .in_group_2 (in_group_2),
    .in_group_3 (in_group_3),
    .in_group_4 (in_group_4),
    .in_group_5 (in_group_5),
    .in_group_6 (in_group_6),
    .in_group_7 (in_group_7),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_job      (push_job)
  );

  // Buffer classified requests
  ipv6cf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_job   (head_job)
  );

  // Emit text one character per cycle while the output is not stalled
  ipv6cf_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .job_valid     (q_valid),
    .job           (head_job),
    .job_pop       (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char_code (out_char_code),
    .out_last      (out_last)
  );

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import ipv6cf_pkg::*;

  localparam int               CYCLE_LIMIT = 2_000_000;
  localparam int               DRAIN_WAIT  = 60;
  localparam int               LONG_HOLD   = 400;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 7'h61;

  // One address request waiting to be offered, optionally after a full drain
  typedef struct {
    logic [NUM_GROUPS-1:0][GROUP_W-1:0] grp;
    bit                                 drain;
  } addr_req_t;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_char_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [GROUP_W-1:0] in_group_0 = '0;
  logic [GROUP_W-1:0] in_group_1 = '0;
  logic [GROUP_W-1:0] in_group_2 = '0;
  logic [GROUP_W-1:0] in_group_3 = '0;
  logic [GROUP_W-1:0] in_group_4 = '0;
  logic [GROUP_W-1:0] in_group_5 = '0;
  logic [GROUP_W-1:0] in_group_6 = '0;
  logic [GROUP_W-1:0] in_group_7 = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [CHAR_W-1:0]  out_char_code;
  logic               out_last;

  addr_req_t                          addr_backlog[$];
  text_char_t                         expected_text[$];
  logic [CHAR_W-1:0]                  text_buf[$];
  logic [NUM_GROUPS-1:0][GROUP_W-1:0] grp_on_bus;
  int                                 cycle_cnt = 0;
  int                                 mismatch_cnt = 0;
  int                                 chars_seen = 0;
  int                                 gap_left = 0;
  int                                 stall_left = 0;
  bit                                 long_hold_done = 1'b0;

  ipv6_canonical_formatter_core u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_group_0    (in_group_0),
    .in_group_1    (in_group_1),
    .in_group_2    (in_group_2),
    .in_group_3    (in_group_3),
    .in_group_4    (in_group_4),
    .in_group_5    (in_group_5),
    .in_group_6    (in_group_6),
    .in_group_7    (in_group_7),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char_code (out_char_code),
    .out_last      (out_last)
  );

  always #5 clk = ~clk;

  // Count cycles and stop a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Lowercase hex without leading zeros
  function automatic void add_hex(input logic [GROUP_W-1:0] v);
    bit       started;
    logic [3:0] nib;
    int       s;
    started = 1'b0;
    for (s = 3; s >= 0; s--) begin
      nib = v[s*4 +: 4];
      if (nib != 4'h0 || started || s == 0) begin
        if (nib < 4'd10) begin
          text_buf.push_back(CH_ZERO + 7'(nib));
        end else begin
          text_buf.push_back(CH_LOWER_A + 7'(nib) - 7'd10);
        end
        started = 1'b1;
      end
    end
  endfunction

  // Decimal octet without leading zeros
  function automatic void add_octet(input logic [7:0] v);
    int h;
    int t;
    int o;
    h = v / 100;
    t = (v / 10) % 10;
    o = v % 10;
    if (h != 0) begin
      text_buf.push_back(CH_ZERO + 7'(h));
    end
    if (h != 0 || t != 0) begin
      text_buf.push_back(CH_ZERO + 7'(t));
    end
    text_buf.push_back(CH_ZERO + 7'(o));
  endfunction

  // Build the canonical text of one address and queue its characters
  function automatic void format_address(input logic [NUM_GROUPS-1:0][GROUP_W-1:0] g);
    int best_s;
    int best_n;
    int run_s;
    int run_n;
    int i;
    best_s = -1;
    best_n = 0;
    run_s  = -1;
    run_n  = 0;
    // find the first longest zero run
    for (i = 0; i < NUM_GROUPS; i++) begin
      if (g[i] != '0) begin
        run_s = -1;
      end else begin
        if (run_s < 0) begin
          run_s = i;
          run_n = 0;
        end
        run_n++;
        if (run_n > best_n) begin
          best_n = run_n;
          best_s = run_s;
        end
      end
    end
    if (best_n < 2) begin
      best_s = -1;
    end

    text_buf.delete();
    if (best_s == 0 && best_n == 5 && g[5] == 16'hffff) begin
      // mapped IPv4 form
      text_buf.push_back(CH_COLON);
      text_buf.push_back(CH_COLON);
      add_hex(16'hffff);
      text_buf.push_back(CH_COLON);
      add_octet(g[6][15:8]);
      text_buf.push_back(CH_DOT);
      add_octet(g[6][7:0]);
      text_buf.push_back(CH_DOT);
      add_octet(g[7][15:8]);
      text_buf.push_back(CH_DOT);
      add_octet(g[7][7:0]);
    end else begin
      for (i = 0; i < NUM_GROUPS; i++) begin
        if (best_s >= 0 && i >= best_s && i < best_s + best_n) begin
          if (i == best_s) begin
            text_buf.push_back(CH_COLON);
          end
        end else begin
          if (i > 0) begin
            text_buf.push_back(CH_COLON);
          end
          add_hex(g[i]);
        end
      end
      if (best_s >= 0 && best_s + best_n == NUM_GROUPS) begin
        text_buf.push_back(CH_COLON);
      end
    end

    foreach (text_buf[k]) begin
      expected_text.push_back('{text_buf[k], (k == text_buf.size() - 1)});
    end
  endfunction

  // Mostly short pauses, a few long ones
  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 10);
    end else begin
      return $urandom_range(15, 40);
    end
  endfunction

  function automatic logic [GROUP_W-1:0] rand_group();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) begin
      return '0;
    end else if (r == 4) begin
      return 16'hffff;
    end else if (r < 7) begin
      return 16'($urandom);
    end else begin
      return 16'($urandom) >> (4 * $urandom_range(0, 3));
    end
  endfunction

  function automatic logic [7:0] rand_octet();
    int r;
    r = $urandom_range(0, 3);
    if (r == 0) begin
      return 8'($urandom_range(0, 9));
    end else if (r == 1) begin
      return 8'($urandom_range(10, 99));
    end else begin
      return 8'($urandom);
    end
  endfunction

  task automatic queue_addr(input logic [GROUP_W-1:0] g0, input logic [GROUP_W-1:0] g1,
                            input logic [GROUP_W-1:0] g2, input logic [GROUP_W-1:0] g3,
                            input logic [GROUP_W-1:0] g4, input logic [GROUP_W-1:0] g5,
                            input logic [GROUP_W-1:0] g6, input logic [GROUP_W-1:0] g7,
                            input bit drain);
    addr_req_t req;
    req.grp[0] = g0;
    req.grp[1] = g1;
    req.grp[2] = g2;
    req.grp[3] = g3;
    req.grp[4] = g4;
    req.grp[5] = g5;
    req.grp[6] = g6;
    req.grp[7] = g7;
    req.drain  = drain;
    addr_backlog.push_back(req);
  endtask

  // Offer queued requests; hold the payload while stalled
  always @(posedge clk) begin
    addr_req_t req;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        format_address(grp_on_bus);
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (addr_backlog.size() != 0 &&
                     !(addr_backlog[0].drain && expected_text.size() != 0)) begin
          req        = addr_backlog.pop_front();
          grp_on_bus = req.grp;
          in_group_0 <= req.grp[0];
          in_group_1 <= req.grp[1];
          in_group_2 <= req.grp[2];
          in_group_3 <= req.grp[3];
          in_group_4 <= req.grp[4];
          in_group_5 <= req.grp[5];
          in_group_6 <= req.grp[6];
          in_group_7 <= req.grp[7];
          in_valid   <= 1'b1;
          // calm phase: back-to-back requests
          if (cycle_cnt[10:9] != 2'd1 && $urandom_range(0, 2) == 0) begin
            gap_left = pick_pause();
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Check each character against the oldest expected one, then pick the next stall
  always @(posedge clk) begin
    text_char_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_text.size() == 0) begin
          $display("%0t: unexpected character: expected none, actual code %h last %b",
                   $time, out_char_code, out_last);
          mismatch_cnt++;
        end else begin
          want = expected_text.pop_front();
          if (out_char_code !== want.code) begin
            $display("%0t: char_code mismatch: expected %h, actual %h",
                     $time, want.code, out_char_code);
            mismatch_cnt++;
          end
          if (out_last !== want.last) begin
            $display("%0t: last mismatch: expected %b, actual %b",
                     $time, want.last, out_last);
            mismatch_cnt++;
          end
        end
        chars_seen++;
      end

      // one long hold-off so the input side backs up
      if (stall_left == 0 && !long_hold_done && chars_seen >= 300) begin
        long_hold_done = 1'b1;
        stall_left     = LONG_HOLD;
      end else if (stall_left == 0 && cycle_cnt[10:9] != 2'd2 &&
                   $urandom_range(0, 3) == 0) begin
        stall_left = pick_pause();
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int         i;
    int         kind;
    logic [GROUP_W-1:0] g[NUM_GROUPS];

    // directed: extremes, ties, single zeros, runs at either end, mapped form
    queue_addr(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0);
    queue_addr(16'hffff, 16'hffff, 16'hffff, 16'hffff,
               16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b0);
    queue_addr(16'h1, 16'h0, 16'h0, 16'h2, 16'h0, 16'h0, 16'h3, 16'h4, 1'b0);
    queue_addr(16'h1, 16'h0, 16'h0, 16'h2, 16'h3, 16'h4, 16'h0, 16'h0, 1'b0);
    queue_addr(16'h1, 16'h0, 16'h2, 16'h3, 16'h4, 16'h5, 16'h6, 16'h7, 1'b0);
    queue_addr(16'h1, 16'h2, 16'h3, 16'h4, 16'h5, 16'h6, 16'h0, 16'h0, 1'b0);
    queue_addr(16'h1, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0);
    queue_addr(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h1, 1'b0);
    queue_addr(16'h8000, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0);
    queue_addr(16'h0, 16'h0, 16'h1, 16'h0, 16'h0, 16'h0, 16'h2, 16'h3, 1'b0);
    queue_addr(16'h0, 16'h1, 16'h0, 16'h1, 16'h0, 16'h1, 16'h0, 16'h1, 1'b0);
    queue_addr(16'h000f, 16'h00f0, 16'h0f00, 16'hf000,
               16'h0010, 16'h0100, 16'h1000, 16'habcd, 1'b0);
    queue_addr(16'h1234, 16'h5678, 16'h9abc, 16'hdef0,
               16'h1111, 16'h2222, 16'h3333, 16'h4444, 1'b0);
    queue_addr(16'h2001, 16'h0db8, 16'h0, 16'h0, 16'h8, 16'h800, 16'h200c, 16'h417a, 1'b0);
    queue_addr(16'h0, 16'h0, 16'h0, 16'h0, 16'hffff, 16'h0, 16'h0, 16'h0, 1'b0);
    queue_addr(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'hffff, 16'hc0a8, 16'h0101, 1'b0);
    queue_addr(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'hffff, 16'h0, 16'h0, 1'b0);
    queue_addr(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'hffff, 16'hffff, 16'hffff, 1'b0);
    queue_addr(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'hffff, 16'h0a64, 16'h09ff, 1'b0);
    queue_addr(16'h0, 16'h0, 16'h0, 16'h0, 16'h1, 16'hffff, 16'hc0a8, 16'h0101, 1'b0);
    queue_addr(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'hfffe, 16'h1, 16'h2, 1'b0);
    queue_addr(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'hc0a8, 16'h0101, 1'b0);
    queue_addr(16'h1, 16'h0, 16'h0, 16'h0, 16'h0, 16'hffff, 16'h0, 16'h0, 1'b0);

    // random: mapped and near-mapped forms, zero-heavy groups, a drain now and then
    for (i = 0; i < 200; i++) begin
      kind = $urandom_range(0, 19);
      foreach (g[k]) begin
        g[k] = rand_group();
      end
      if (kind < 4) begin
        foreach (g[k]) begin
          g[k] = '0;
        end
        g[5] = 16'hffff;
        g[6] = {rand_octet(), rand_octet()};
        g[7] = {rand_octet(), rand_octet()};
        if (kind == 3) begin
          g[$urandom_range(0, 5)] = rand_group();
        end
      end
      queue_addr(g[0], g[1], g[2], g[3], g[4], g[5], g[6], g[7], (i == 0 || i == 100));
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (addr_backlog.size() != 0 || in_valid) begin
      @(posedge clk);
    end
    while (expected_text.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatch_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
